FILE: sv/bdlp_pkg.sv
// shared types and constants for the button debounce and long press block
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

    localparam int unsigned CountWidth = 16;
    localparam logic [CountWidth-1:0] CountMax = '1;
    localparam logic [CountWidth-1:0] DebounceReset = 16'd50;
    localparam logic [CountWidth-1:0] LongPressReset = 16'd1000;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_CLICK    = 2'd1,
        EV_RELEASED = 2'd2,
        EV_LONG     = 2'd3
    } bdlp_event_t;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_EDGE = 1'b1
    } bdlp_req_t;

    typedef enum logic {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } bdlp_cfg_idx_t;

    typedef struct packed {
        logic [CountWidth-1:0] since_edge_count;
        logic                  stable_high;
        logic                  long_fired;
        logic [CountWidth-1:0] hold_count;
        logic                  hold_timer_on;
    } bdlp_state_t;

endpackage

`default_nettype wire

FILE: sv/bdlp_core.sv
// button state registers and the per-item update logic
`timescale 1ns / 1ps
`default_nettype none

module bdlp_core
    import bdlp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_en,
    input  wire logic                  req_type,
    input  wire logic                  pin_level,
    input  wire logic [CountWidth-1:0] debounce_ticks,
    input  wire logic [CountWidth-1:0] long_press_ticks,
    output bdlp_state_t                state_o,
    output logic                       res_valid,
    output bdlp_event_t                res_event
);

    bdlp_state_t state_reg;
    bdlp_state_t state_next;

    logic [CountWidth-1:0] since_inc;
    logic [CountWidth-1:0] hold_inc;
    logic [CountWidth-1:0] limit;

    assign since_inc = (state_reg.since_edge_count == CountMax) ?
                       state_reg.since_edge_count : state_reg.since_edge_count + 1'b1;
    assign hold_inc  = (state_reg.hold_count == CountMax) ?
                       state_reg.hold_count : state_reg.hold_count + 1'b1;
    // a zero length counts as one tick
    assign limit     = (long_press_ticks == '0) ? CountWidth'(1) : long_press_ticks;

    always_comb begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res_event  = EV_PRESSED;
        if (item_en) begin
            if (bdlp_req_t'(req_type) == REQ_TICK) begin
                state_next.since_edge_count = since_inc;
                if (state_reg.hold_timer_on) begin
                    state_next.hold_count = hold_inc;
                    if (hold_inc >= limit) begin
                        state_next.hold_timer_on = 1'b0;
                        state_next.hold_count    = '0;
                        if (!state_reg.stable_high && !state_reg.long_fired) begin
                            state_next.long_fired = 1'b1;
                            res_valid             = 1'b1;
                            res_event             = EV_LONG;
                        end
                    end
                end
            end else if (state_reg.since_edge_count >= debounce_ticks) begin
                // accepted edge restarts the debounce count even with no level change
                state_next.since_edge_count = '0;
                if (!pin_level && state_reg.stable_high) begin
                    state_next.stable_high   = 1'b0;
                    state_next.long_fired    = 1'b0;
                    state_next.hold_timer_on = 1'b1;
                    state_next.hold_count    = '0;
                    res_valid                = 1'b1;
                    res_event                = EV_PRESSED;
                end else if (pin_level && !state_reg.stable_high) begin
                    state_next.stable_high   = 1'b1;
                    state_next.hold_timer_on = 1'b0;
                    state_next.hold_count    = '0;
                    res_valid                = 1'b1;
                    res_event                = state_reg.long_fired ? EV_RELEASED : EV_CLICK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{since_edge_count: '0, stable_high: 1'b1, long_fired: 1'b0,
                           hold_count: '0, hold_timer_on: 1'b0};
        end else begin
            state_reg <= state_next;
        end
    end

    assign state_o = state_reg;

endmodule

`default_nettype wire

FILE: sv/bdlp_out_buf.sv
// two-entry result buffer between the update logic and the result channel
`timescale 1ns / 1ps
`default_nettype none

module bdlp_out_buf
    import bdlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire bdlp_event_t push_event,
    output logic             can_accept,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_button_event
);

    bdlp_event_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop        = m_valid && m_ready;
    assign can_accept = (count_reg != 2'd2);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_event;
        end
    end

    assign m_valid        = (count_reg != 2'd0);
    assign m_button_event = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: sv/button_debounce_long_press_core.sv
// top level: button debounce with click and long press events
//
//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  input    | s_valid s_ready s_req_type s_pin_level      | in
//  result   | m_valid m_ready m_button_event              | out
//  config   | cfg_valid cfg_ready cfg_index cfg_data      | in
//
// one item per cycle while the result buffer has room; an item is held in the input
// register, processed against the button state, and its result, if any, is
// written into the result buffer, from which it drives m_valid
// the state update is combinational between the input register and the
// two-entry result buffer; a stalled result side holds off input only when both
// buffer entries are full
// synchronous active-low reset; config writes are always taken
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic                  s_pin_level,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_button_event,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CountWidth-1:0] cfg_data
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  req_type_reg;
    logic                  pin_level_reg;
    logic [CountWidth-1:0] debounce_reg;
    logic [CountWidth-1:0] long_press_reg;
    logic                  buf_can_accept;
    logic                  advance;
    logic                  res_valid;
    bdlp_event_t           res_event;
    bdlp_state_t           state;

    assign advance   = in_valid_reg && buf_can_accept;
    assign s_ready   = !in_valid_reg || buf_can_accept;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            debounce_reg   <= DebounceReset;
            long_press_reg <= LongPressReset;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (bdlp_cfg_idx_t'(cfg_index) == CFG_DEBOUNCE) begin
                    debounce_reg <= cfg_data;
                end else begin
                    long_press_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg  <= s_req_type;
            pin_level_reg <= s_pin_level;
        end
    end

    bdlp_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_en          (advance),
        .req_type         (req_type_reg),
        .pin_level        (pin_level_reg),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .state_o          (state),
        .res_valid        (res_valid),
        .res_event        (res_event)
    );

    bdlp_out_buf u_out_buf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (res_valid),
        .push_event     (res_event),
        .can_accept     (buf_can_accept),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_event (m_button_event)
    );

    // the hold timer only runs while the button is down
    a_timer_when_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        state.hold_timer_on |-> !state.stable_high)
        else $error("hold timer running while released");

    // a long press is reported once per hold and marks it fired
    a_long_marks_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_event == EV_LONG) |-> (!state.long_fired && !state.stable_high))
        else $error("long press reported twice or while released");

    a_long_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_event == EV_LONG) |=> state.long_fired)
        else $error("long press did not set its flag");

    // a press starts the timer from zero
    a_press_starts_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_event == EV_PRESSED) |=>
            (state.hold_timer_on && !state.stable_high && state.hold_count == '0))
        else $error("press did not start the hold timer");

    // results are only produced while the buffer has room
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> buf_can_accept)
        else $error("result pushed into a full buffer");

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for button_debounce_long_press_core: directed rows, then random press sequences
`timescale 1ns / 1ps

module tb;
    import bdlp_pkg::*;

    localparam int          SettleCycles = 8;
    localparam int unsigned CycleLimit   = 3_000_000;
    localparam int          RandPhases   = 12;
    localparam int          PhaseItems   = 85;
    localparam int          DirRows      = 30;

    typedef enum logic [1:0] {
        ROW_CFG,    // register write, block drained first
        ROW_PRED,   // item checked against the predictor
        ROW_QUIET,  // item that must give no event
        ROW_EVENT   // item that must give the event in the row
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE
    } rx_style_t;

    typedef struct packed {
        row_kind_t             kind;
        bdlp_cfg_idx_t         idx;
        logic [CountWidth-1:0] data;
        bdlp_req_t             req;
        logic                  lvl;
        bdlp_event_t           ev;
    } dir_step_t;

    localparam dir_step_t DirSteps [DirRows] = '{
        // defaults: edges right after reset fall inside the debounce window
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b1, EV_PRESSED},
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_PRESSED},
        '{ROW_CFG,   CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_CFG,   CFG_LONG_PRESS, 16'd2, REQ_TICK, 1'b0, EV_PRESSED},
        // zero debounce: repeat of the released level is taken silently
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b1, EV_LONG},
        '{ROW_QUIET, CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_RELEASED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_CLICK},
        // zero long-press length acts as one tick
        '{ROW_CFG,   CFG_LONG_PRESS, 16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_LONG},
        '{ROW_EVENT, CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_RELEASED},
        '{ROW_CFG,   CFG_DEBOUNCE,   16'd3, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b1, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b0, EV_PRESSED},
        // new long-press length while the hold timer runs
        '{ROW_CFG,   CFG_LONG_PRESS, 16'd4, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b1, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b1, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_TICK, 1'b0, EV_PRESSED},
        '{ROW_PRED,  CFG_DEBOUNCE,   16'd0, REQ_EDGE, 1'b1, EV_PRESSED}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic                  s_pin_level;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_button_event;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CountWidth-1:0] cfg_data;

    // predictor copy of the button state and registers
    logic [CountWidth-1:0] since_ticks;
    logic [CountWidth-1:0] held_ticks;
    logic [CountWidth-1:0] debounce_len;
    logic [CountWidth-1:0] long_len;
    logic                  btn_released;
    logic                  long_sent;
    logic                  hold_running;

    bdlp_event_t expected_events[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          live_items     = 0;
    int          events_seen    = 0;
    int          cfg_writes     = 0;
    int          burst_left     = 0;
    int unsigned cycle_count    = 0;

    button_debounce_long_press_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_pin_level    (s_pin_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_event (m_button_event),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        while (cycle_count < CycleLimit) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // returns 1 when the item raises an event; ignored flags a filtered edge
    function automatic bit predict_button_event(input bdlp_req_t req, input logic lvl,
                                                output bdlp_event_t ev, output bit ignored);
        logic [CountWidth-1:0] lim;
        bit                    fired;
        fired   = 1'b0;
        ignored = 1'b0;
        ev      = EV_PRESSED;
        if (req == REQ_TICK) begin
            if (since_ticks != CountMax) since_ticks++;
            if (hold_running) begin
                if (held_ticks != CountMax) held_ticks++;
                lim = (long_len == '0) ? 16'd1 : long_len;
                if (held_ticks >= lim) begin
                    hold_running = 1'b0;
                    held_ticks   = '0;
                    if (!btn_released && !long_sent) begin
                        long_sent = 1'b1;
                        ev        = EV_LONG;
                        fired     = 1'b1;
                    end
                end
            end
        end else if (since_ticks < debounce_len) begin
            ignored = 1'b1;
        end else begin
            since_ticks = '0;
            if (!lvl && btn_released) begin
                btn_released = 1'b0;
                long_sent    = 1'b0;
                hold_running = 1'b1;
                held_ticks   = '0;
                ev           = EV_PRESSED;
                fired        = 1'b1;
            end else if (lvl && !btn_released) begin
                btn_released = 1'b1;
                hold_running = 1'b0;
                held_ticks   = '0;
                ev           = long_sent ? EV_RELEASED : EV_CLICK;
                fired        = 1'b1;
            end
        end
        return fired;
    endfunction

    task automatic send_item(input bdlp_req_t req, input logic lvl, input row_kind_t how,
                             input bdlp_event_t typed_ev);
        int          gap;
        bit          fired;
        bit          ignored;
        bdlp_event_t ev;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_pin_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fired = predict_button_event(req, lvl, ev, ignored);
        items_sent++;
        if (!ignored) live_items++;
        case (how)
            ROW_QUIET: ;
            ROW_EVENT: expected_events.push_back(typed_ev);
            default:   if (fired) expected_events.push_back(ev);
        endcase
    endtask

    // sender holds off until every pending event is back and the pipe is quiet
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_reg(input bdlp_cfg_idx_t idx, input logic [CountWidth-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE:   debounce_len = data;
            CFG_LONG_PRESS: long_len     = data;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side stalls in stretches of its own
    initial begin : result_stall
        rx_style_t style;
        int        hold_left;
        m_ready   = 1'b0;
        hold_left = 0;
        style     = RX_OPEN;
        forever begin
            @(negedge aclk);
            if (hold_left == 0) begin
                style     = rx_style_t'($urandom_range(0, 2));
                hold_left = $urandom_range(10, 100);
            end
            hold_left--;
            case (style)
                RX_OPEN:  m_ready <= 1'b1;
                RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
                default:  m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_events
        bdlp_event_t want;
        if (aresetn && m_valid && m_ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
                $error("button_event: expected none, actual %0d", m_button_event);
                mismatch_count++;
            end else begin
                want = expected_events.pop_front();
                if (m_button_event !== want) begin
                    $error("button_event: expected %0d, actual %0d", want, m_button_event);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          start;
        int          span;
        int          pick;
        logic        lvl;
        dir_step_t   row;
        s_valid      = 1'b0;
        s_req_type   = REQ_TICK;
        s_pin_level  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEBOUNCE;
        cfg_data     = '0;
        aresetn      = 1'b0;
        since_ticks  = '0;
        held_ticks   = '0;
        debounce_len = DebounceReset;
        long_len     = LongPressReset;
        btn_released = 1'b1;
        long_sent    = 1'b0;
        hold_running = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DirRows; i++) begin
            row = DirSteps[i];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.req, row.lvl, row.kind, row.ev);
            end
        end

        for (ph = 0; ph < RandPhases; ph++) begin
            wait_drained();
            if (ph == 0) begin
                write_reg(CFG_DEBOUNCE, 16'd0);
                write_reg(CFG_LONG_PRESS, 16'd1);
            end else if (ph == 1) begin
                write_reg(CFG_DEBOUNCE, 16'd1);
                write_reg(CFG_LONG_PRESS, 16'd0);
            end else begin
                write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 6)));
                write_reg(CFG_LONG_PRESS,
                          ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 15)));
            end
            start = live_items;
            while (live_items - start < PhaseItems) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    // ticks to just around the debounce or long-press point, then an edge
                    if (!btn_released && $urandom_range(0, 2) == 0)
                        span = ((long_len == '0) ? 1 : int'(long_len)) - 1
                               + $urandom_range(0, 2);
                    else if (debounce_len != '0 && $urandom_range(0, 5) == 0)
                        span = int'(debounce_len) - 1;
                    else
                        span = int'(debounce_len) + $urandom_range(0, 2);
                    repeat (span)
                        send_item(REQ_TICK, 1'($urandom_range(0, 1)), ROW_PRED, EV_PRESSED);
                    lvl = ($urandom_range(0, 5) == 0) ? logic'($urandom_range(0, 1))
                                                       : ~btn_released;
                    send_item(REQ_EDGE, lvl, ROW_PRED, EV_PRESSED);
                end else if (pick < 9) begin
                    send_item(bdlp_req_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              ROW_PRED, EV_PRESSED);
                end else begin
                    // contact bounce
                    repeat ($urandom_range(2, 5))
                        send_item(REQ_EDGE, 1'($urandom_range(0, 1)), ROW_PRED, EV_PRESSED);
                end
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SettleCycles) @(posedge aclk);

        $display("ran %0d items (%0d past the debounce filter), %0d events, %0d reg writes",
                 items_sent, live_items, events_seen, cfg_writes);
        $display("debounce and long-press lengths swept over short values, zero included");
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
